// ----- rtl/s2i_pkg.sv -----
`default_nettype none

package s2i_pkg;

    localparam int VALUE_W = 64;
    localparam int BASE_W  = 7;
    localparam int DIGIT_W = 8;
    localparam int CFG_W   = 6;
    localparam int CHAR_W  = 8;

    localparam logic [CHAR_W-1:0] CH_BLANK_MAX = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS     = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS      = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_STAR      = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE      = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A_UPPER   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_Z_UPPER   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_X_UPPER   = 8'h58;
    localparam logic [CHAR_W-1:0] CH_X_LOWER   = 8'h78;
    localparam logic [CHAR_W-1:0] CH_ASCII_MAX = 8'h7F;
    localparam logic [CHAR_W-1:0] CASE_SHIFT   = 8'd32;

    localparam logic [BASE_W-1:0] LETTER_GAP = 7'd7;
    localparam logic [BASE_W-1:0] BASE_OCT   = 7'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 7'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 7'd16;

    typedef struct packed {
        logic                 is_blank;
        logic                 is_minus;
        logic                 is_plus;
        logic                 is_zero;
        logic                 is_x_lower;
        logic                 is_base_mark;
        logic                 digit_ok;
        logic [DIGIT_W-1:0]   digit;
        logic [BASE_W-1:0]    base_char;
    } t_char_info;

endpackage

`default_nettype wire

// ----- rtl/s2i_char_dec.sv -----
`default_nettype none

module s2i_char_dec (
    input  wire logic [s2i_pkg::CHAR_W-1:0] i_char,
    output s2i_pkg::t_char_info             o_info
);
    import s2i_pkg::*;

    logic [CHAR_W-1:0] w_folded;
    logic [BASE_W-1:0] w_base_raw;

    always_comb begin
        o_info              = '0;
        o_info.is_blank     = (i_char <= CH_BLANK_MAX);
        o_info.is_minus     = (i_char == CH_MINUS);
        o_info.is_plus      = (i_char == CH_PLUS);
        o_info.is_zero      = (i_char == CH_ZERO);
        o_info.is_x_lower   = (i_char == CH_X_LOWER);
        o_info.is_base_mark = (i_char == CH_X_LOWER) || (i_char == CH_X_UPPER) ||
                              (i_char == CH_STAR);

        // digit value; bytes above 'Z' fold down by 32 before the letter test
        w_folded = (i_char > CH_Z_UPPER) ? (i_char - CASE_SHIFT) : i_char;
        if (i_char < CH_ZERO) begin
            o_info.digit_ok = 1'b0;
        end else if (i_char <= CH_NINE) begin
            o_info.digit_ok = 1'b1;
            o_info.digit    = i_char - CH_ZERO;
        end else if (w_folded < CH_A_UPPER) begin
            o_info.digit_ok = 1'b0;
        end else begin
            o_info.digit_ok = 1'b1;
            o_info.digit    = w_folded - CH_A_UPPER + DIGIT_W'(10);
        end

        // base taken from the character after an 'x', 'X' or '*' prefix
        w_base_raw = i_char[BASE_W-1:0] - CH_ZERO[BASE_W-1:0];
        if (i_char < CH_ZERO || i_char > CH_ASCII_MAX) begin
            o_info.base_char = BASE_DEC;
        end else begin
            o_info.base_char = (w_base_raw > 7'd9) ? (w_base_raw - LETTER_GAP) : w_base_raw;
            if (o_info.base_char == '0) begin
                o_info.base_char = BASE_DEC;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/s2i_core.sv -----
`default_nettype none

module s2i_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [s2i_pkg::CFG_W-1:0]   i_fixed_base,
    input  wire logic                        i_valid,
    input  wire logic                        i_no_char,
    input  wire logic                        i_last_byte,
    input  s2i_pkg::t_char_info              i_info,
    output logic                             o_go,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [s2i_pkg::VALUE_W-1:0]      o_value
);
    import s2i_pkg::*;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_PREFIX,
        PH_AFTER_ZERO,
        PH_BASE_CHAR,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    t_phase             r_phase, n_phase;
    logic               r_neg, n_neg;
    logic [BASE_W-1:0]  r_base, n_base;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic               r_out_valid, n_out_valid;
    logic [VALUE_W-1:0] r_out_value, n_out_value;

    logic               w_take;
    logic [BASE_W-1:0]  w_take_base;
    logic               w_pick_base;
    logic [VALUE_W-1:0] w_prod;
    logic [VALUE_W-1:0] w_sdigit;

    assign o_go        = i_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;

    // sign is known before any digit, so negative numbers accumulate downward
    assign w_sdigit = r_neg ? (VALUE_W'(0) - {{(VALUE_W-DIGIT_W){1'b0}}, i_info.digit})
                            : {{(VALUE_W-DIGIT_W){1'b0}}, i_info.digit};

    always_comb begin
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_base      = r_base;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_value = r_out_value;
        w_take      = 1'b0;
        w_take_base = r_base;
        w_pick_base = 1'b0;
        w_prod      = '0;

        if (o_go && !i_no_char) begin
            unique case (r_phase)
                PH_SKIP: begin
                    if (i_info.is_blank) begin
                        n_phase = r_phase;
                    end else if (i_info.is_minus) begin
                        n_neg   = 1'b1;
                        n_phase = PH_PREFIX;
                    end else if (i_info.is_plus) begin
                        n_phase = PH_PREFIX;
                    end else begin
                        w_pick_base = 1'b1;
                    end
                end
                PH_PREFIX: begin
                    w_pick_base = 1'b1;
                end
                PH_AFTER_ZERO: begin
                    if (i_info.is_x_lower) begin
                        n_base  = BASE_HEX;
                        n_phase = PH_DIGITS;
                    end else begin
                        w_take = 1'b1;
                    end
                end
                PH_BASE_CHAR: begin
                    n_base  = i_info.base_char;
                    n_phase = PH_DIGITS;
                end
                PH_DIGITS: begin
                    w_take = 1'b1;
                end
                PH_DONE: begin
                    n_phase = r_phase;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase

            if (w_pick_base) begin
                if (i_fixed_base != '0) begin
                    n_base      = {{(BASE_W-CFG_W){1'b0}}, i_fixed_base};
                    w_take_base = n_base;
                    w_take      = 1'b1;
                end else if (i_info.is_zero) begin
                    n_base  = BASE_OCT;
                    n_phase = PH_AFTER_ZERO;
                end else if (i_info.is_base_mark) begin
                    n_phase = PH_BASE_CHAR;
                end else begin
                    n_base      = BASE_DEC;
                    w_take_base = BASE_DEC;
                    w_take      = 1'b1;
                end
            end

            w_prod = r_acc * {{(VALUE_W-BASE_W){1'b0}}, w_take_base};

            if (w_take) begin
                if (i_info.digit_ok && (i_info.digit < {1'b0, w_take_base})) begin
                    n_acc   = w_prod + w_sdigit;
                    n_phase = PH_DIGITS;
                end else begin
                    n_phase = PH_DONE;
                end
            end
        end

        if (o_go && (i_last_byte || i_no_char)) begin
            n_out_valid = 1'b1;
            n_out_value = n_acc;
            n_phase     = PH_SKIP;
            n_neg       = 1'b0;
            n_base      = '0;
            n_acc       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SKIP;
            r_neg       <= 1'b0;
            r_base      <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_base      <= n_base;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
        r_out_value <= n_out_value;
    end

endmodule

`default_nettype wire

// ----- rtl/string_to_int64_parser_top.sv -----
// Streaming text-to-integer parser, one character per transaction.
// The accepting edge loads the input register; the parse stage then loads the result register
// from it, once any held result has been taken by i_out_ready.
// Throughput: one character per cycle while no result waits on i_out_ready; the
// accumulator update (64x7 multiply-add) is combinational, which sets the rate.
// Reset (synchronous, active low) clears the parser state, valids and fixed_base.
`default_nettype none

module string_to_int64_parser_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [s2i_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [s2i_pkg::CHAR_W-1:0]  i_text_byte,
    input  wire logic                        i_no_char,
    input  wire logic                        i_last_byte,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic signed [s2i_pkg::VALUE_W-1:0] o_value
);
    import s2i_pkg::*;

    logic [CFG_W-1:0]   r_fixed_base;
    logic               r_in_valid;
    logic [CHAR_W-1:0]  r_text_byte;
    logic               r_no_char;
    logic               r_last_byte;
    logic               w_go;
    logic [VALUE_W-1:0] w_value;
    t_char_info         w_info;

    assign o_in_ready = !r_in_valid || w_go;
    assign o_value    = signed'(w_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixed_base <= '0;
            r_in_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fixed_base <= i_cfg_wdata;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
        end
        if (o_in_ready && i_in_valid) begin
            r_text_byte <= i_text_byte;
            r_no_char   <= i_no_char;
            r_last_byte <= i_last_byte;
        end
    end

    s2i_char_dec u_char_dec (
        .i_char (r_text_byte),
        .o_info (w_info)
    );

    s2i_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fixed_base (r_fixed_base),
        .i_valid      (r_in_valid),
        .i_no_char    (r_no_char),
        .i_last_byte  (r_last_byte),
        .i_info       (w_info),
        .o_go         (w_go),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_value      (w_value)
    );

endmodule

`default_nettype wire
